// ----- hdl/polygon_winding_number_top_defines.svh -----
// Assertion macros shared by the polygon winding number block.
`ifndef POLYGON_WINDING_NUMBER_TOP_DEFINES_SVH
`define POLYGON_WINDING_NUMBER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwn assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PWN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwn assertion failed");

`endif

// ----- hdl/pwn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pwn_pkg;

    localparam int TOL_BITS  = 31;
    localparam int WIND_BITS = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_BOUND = 2'd2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_L,
        BK_MUL_R,
        BK_MUL_T,
        BK_EVAL
    } bk_state_t;

    typedef struct packed {
        logic       first;
        logic       seg;
        logic       last;
        logic       closed;
        logic       span_out;
        logic       both_right;
        logic       both_eq;
        logic       pt_eq;
        logic       vertical;
        logic       vert_touch;
        logic       in_xspan;
        logic       dy_pos;
        logic       dy_zero;
        logic [2:0] delta;
    } job_flags_t;

endpackage
`default_nettype wire

// ----- hdl/pwn_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwn_front #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic                         first_vertex,
    input  wire logic                         last_vertex,
    input  wire logic                         fifo_full,
    output logic                              push,
    output pwn_pkg::job_flags_t               flags,
    output logic signed [COORD_BITS:0]        ex,
    output logic signed [COORD_BITS:0]        ey,
    output logic signed [COORD_BITS:0]        dx,
    output logic signed [COORD_BITS:0]        dy
);
    import pwn_pkg::*;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, sx_reg, sy_reg, px_reg, py_reg;
    logic                         have_prev_reg;
    logic                         accept;
    logic signed [COORD_BITS-1:0] x, y, x1, y1, x2, y2;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign push     = accept && (first_vertex || have_prev_reg);

    assign x  = qx_reg;
    assign y  = qy_reg;
    assign x1 = px_reg;
    assign y1 = py_reg;
    assign x2 = vertex_x;
    assign y2 = vertex_y;

    always_comb
    begin
        ex = {x[COORD_BITS-1], x} - {x1[COORD_BITS-1], x1};
        ey = {y[COORD_BITS-1], y} - {y1[COORD_BITS-1], y1};
        dx = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
        dy = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};
        flags.first      = first_vertex;
        flags.seg        = !first_vertex;
        flags.last       = last_vertex;
        flags.closed     = first_vertex || (vertex_x == sx_reg && vertex_y == sy_reg);
        flags.span_out   = (y1 > y && y2 > y) || (y1 < y && y2 < y);
        flags.both_right = x1 > x && x2 > x;
        flags.both_eq    = x1 == x && x2 == x;
        flags.pt_eq      = x == x1 && y == y1;
        flags.vertical   = x1 == x2;
        flags.vert_touch = x == x1 && (y1 <= y || y2 <= y) && (y1 >= y || y2 >= y);
        flags.in_xspan   = (x1 <= x || x2 <= x) && (x1 >= x || x2 >= x);
        flags.dy_pos     = y2 > y1;
        flags.dy_zero    = y2 == y1;
        if (y1 < y && y2 > y)
            flags.delta = 3'sd2;
        else if (y1 > y && y2 < y)
            flags.delta = -3'sd2;
        else if (y1 == y && y2 < y)
            flags.delta = -3'sd1;
        else if (y1 == y && y2 > y)
            flags.delta = 3'sd1;
        else if (y1 < y && y2 == y)
            flags.delta = 3'sd1;
        else if (y1 > y && y2 == y)
            flags.delta = -3'sd1;
        else
            flags.delta = 3'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            qx_reg <= '0;
            qy_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
        end
        else if (push)
        begin
            if (first_vertex)
            begin
                qx_reg <= point_x;
                qy_reg <= point_y;
                sx_reg <= vertex_x;
                sy_reg <= vertex_y;
            end
            px_reg <= vertex_x;
            py_reg <= vertex_y;
            have_prev_reg <= !last_vertex;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pwn_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pwn_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              full,
    output logic              empty
);
    logic [W-1:0] mem [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pwn_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_winding_number_top_defines.svh"
module pwn_back #(
    parameter int COORD_BITS = 32,
    parameter int COUNT_BITS = 18
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           empty,
    output logic                                pop,
    input  wire pwn_pkg::job_flags_t            jflags,
    input  wire logic signed [COORD_BITS:0]     jex,
    input  wire logic signed [COORD_BITS:0]     jey,
    input  wire logic signed [COORD_BITS:0]     jdx,
    input  wire logic signed [COORD_BITS:0]     jdy,
    input  wire logic [pwn_pkg::TOL_BITS-1:0]   tol,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [pwn_pkg::WIND_BITS-1:0] winding,
    output logic [1:0]                          status,
    output logic                                saturated
);
    import pwn_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int MW = (D + 1 > TOL_BITS + 1) ? D + 1 : TOL_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int CB = COUNT_BITS;
    localparam int EW = (CB > WIND_BITS + 1) ? CB : WIND_BITS + 1;

    bk_state_t state_reg, state_next;

    job_flags_t           f_reg;
    logic signed [D-1:0]  ex_reg, ey_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] l_reg, r_reg, lim_reg;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic [D-1:0]         adx;

    logic signed [CB-1:0] hc_reg, hc_next;
    logic                 bnd_reg, bnd_next;
    logic                 clamp_reg, clamp_next;

    logic                 ov_reg, ov_next;
    logic signed [WIND_BITS-1:0] w_reg, w_next;
    logic [1:0]           st_reg, st_next;
    logic                 sat_reg, sat_next;

    logic signed [PW-1:0] dd, absd;
    logic                 seg_bnd, seg_left, load;
    logic signed [CB:0]   sum;
    logic signed [CB-1:0] hc_base, hc_upd, hc_adj;
    logic                 bnd_base, clamp_base, clamp_upd;
    logic signed [EW-1:0] wq;
    logic                 out_free;

    localparam logic signed [CB:0] TOP = (CB+1)'((1 << (CB - 1)) - 1);
    localparam logic signed [CB:0] BOT = -TOP - (CB+1)'(1);
    localparam logic signed [EW-1:0] WMAX = EW'(32767);
    localparam logic signed [EW-1:0] WMIN = -EW'(32768);

    assign out_valid = ov_reg;
    assign winding   = w_reg;
    assign status    = st_reg;
    assign saturated = sat_reg;
    assign out_free  = !ov_reg || !out_stall;
    assign pop       = state_reg == BK_IDLE && !empty;

    assign adx  = dx_reg[D-1] ? D'(-dx_reg) : D'(dx_reg);
    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            BK_MUL_L:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(dy_reg);
            end
            BK_MUL_R:
            begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(ey_reg);
            end
            BK_MUL_T:
            begin
                mul_a = $signed(MW'(tol));
                mul_b = $signed(MW'(adx));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dd       = r_reg - l_reg;
        absd     = dd[PW-1] ? -dd : dd;
        seg_bnd  = f_reg.pt_eq || (f_reg.vertical ? f_reg.vert_touch
                   : (f_reg.in_xspan && !(lim_reg < absd)));
        seg_left = !f_reg.span_out && (f_reg.both_right || (!f_reg.both_eq && !f_reg.dy_zero
                   && (f_reg.dy_pos ? (l_reg < r_reg) : (r_reg < l_reg))));

        hc_base    = f_reg.first ? '0 : hc_reg;
        bnd_base   = f_reg.first ? 1'b0 : bnd_reg;
        clamp_base = f_reg.first ? 1'b0 : clamp_reg;

        sum = (CB+1)'(hc_base) + (CB+1)'($signed(f_reg.delta));
        if (!(f_reg.seg && seg_left))
        begin
            hc_upd    = hc_base;
            clamp_upd = clamp_base;
        end
        else if (sum > TOP)
        begin
            hc_upd    = CB'(TOP);
            clamp_upd = 1'b1;
        end
        else if (sum < BOT)
        begin
            hc_upd    = CB'(BOT);
            clamp_upd = 1'b1;
        end
        else
        begin
            hc_upd    = CB'(sum);
            clamp_upd = clamp_base;
        end

        hc_adj = hc_upd + CB'({1'b0, hc_upd[CB-1]});
        wq     = EW'(hc_adj >>> 1);
    end

    always_comb
    begin
        state_next = state_reg;
        hc_next    = hc_reg;
        bnd_next   = bnd_reg;
        clamp_next = clamp_reg;
        ov_next    = ov_reg && out_stall;
        w_next     = w_reg;
        st_next    = st_reg;
        sat_next   = sat_reg;
        load       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    load       = 1'b1;
                    state_next = jflags.seg ? BK_MUL_L : BK_EVAL;
                end
            end
            BK_MUL_L:
                state_next = BK_MUL_R;
            BK_MUL_R:
                state_next = BK_MUL_T;
            BK_MUL_T:
                state_next = BK_EVAL;
            BK_EVAL:
            begin
                if (!f_reg.last || out_free)
                begin
                    state_next = BK_IDLE;
                    hc_next    = hc_upd;
                    bnd_next   = bnd_base || (f_reg.seg && seg_bnd);
                    clamp_next = clamp_upd;
                    if (f_reg.last)
                    begin
                        ov_next = 1'b1;
                        if (!f_reg.closed)
                        begin
                            w_next   = '0;
                            st_next  = ST_OPEN;
                            sat_next = 1'b0;
                        end
                        else if (bnd_next)
                        begin
                            w_next   = WIND_BITS'(1);
                            st_next  = ST_BOUND;
                            sat_next = 1'b0;
                        end
                        else
                        begin
                            st_next = ST_OK;
                            if (wq > WMAX)
                            begin
                                w_next   = WIND_BITS'(WMAX);
                                sat_next = 1'b1;
                            end
                            else if (wq < WMIN)
                            begin
                                w_next   = WIND_BITS'(WMIN);
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                w_next   = WIND_BITS'(wq);
                                sat_next = clamp_upd;
                            end
                        end
                    end
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            hc_reg    <= '0;
            bnd_reg   <= 1'b0;
            clamp_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hc_reg    <= hc_next;
            bnd_reg   <= bnd_next;
            clamp_reg <= clamp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        st_reg  <= st_next;
        sat_reg <= sat_next;
        if (load)
        begin
            f_reg  <= jflags;
            ex_reg <= jex;
            ey_reg <= jey;
            dx_reg <= jdx;
            dy_reg <= jdy;
        end
        if (state_reg == BK_MUL_L)
            l_reg <= prod;
        if (state_reg == BK_MUL_R)
            r_reg <= prod;
        if (state_reg == BK_MUL_T)
            lim_reg <= prod;
    end

    `PWN_ASSERT_IMPL(a_pop_only_idle, pop, state_reg == BK_IDLE)
    `PWN_ASSERT_IMPL(a_result_from_eval, $rose(ov_reg), $past(state_reg) == BK_EVAL)
    `PWN_ASSERT_IMPL(a_status_code, ov_reg, st_reg == ST_OK || st_reg == ST_OPEN || st_reg == ST_BOUND)
    `PWN_ASSERT_NEXT(a_mul_chain, state_reg == BK_MUL_L, state_reg == BK_MUL_R)

endmodule
`default_nettype wire

// ----- hdl/polygon_winding_number_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Streams polygon vertices for one query point and returns its winding number after the
// vertex marked last; the point on a vertex or edge gives 1 with boundary status, and a
// polygon whose last vertex differs from its first gives open status. The front accepts a
// vertex word per cycle into a two-entry queue unless it is full. The back takes one vertex
// at a time: three products on one shared multiplier, then an evaluation step, for a vertex
// that closes a segment, and only the evaluation step for a first vertex.
module polygon_winding_number_top #(
    parameter int COORD_BITS = 32,
    parameter int COUNT_BITS = 18
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [COORD_BITS-1:0]   point_x,
    input  wire logic signed [COORD_BITS-1:0]   point_y,
    input  wire logic signed [COORD_BITS-1:0]   vertex_x,
    input  wire logic signed [COORD_BITS-1:0]   vertex_y,
    input  wire logic                           first_vertex,
    input  wire logic                           last_vertex,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [pwn_pkg::WIND_BITS-1:0] winding,
    output logic [1:0]                          status,
    output logic                                saturated
);
    import pwn_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int FW = $bits(job_flags_t) + 4 * D;

    logic [TOL_BITS-1:0] tol_reg;
    logic                push, pop, full, empty;
    job_flags_t          f_in, f_out;
    logic signed [D-1:0] ex, ey, dx, dy, qex, qey, qdx, qdy;
    logic [FW-1:0]       qrd;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {1'b0, tol_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && paddr == 3'd0)
            tol_reg <= pwdata[TOL_BITS-1:0];
    end

    pwn_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .vertex_x(vertex_x), .vertex_y(vertex_y),
        .first_vertex(first_vertex), .last_vertex(last_vertex), .fifo_full(full),
        .push(push), .flags(f_in), .ex(ex), .ey(ey), .dx(dx), .dy(dy)
    );

    pwn_fifo #(.W(FW)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata({f_in, ex, ey, dx, dy}),
        .pop(pop), .rdata(qrd), .full(full), .empty(empty)
    );

    assign {f_out, qex, qey, qdx, qdy} = qrd;

    pwn_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .jflags(f_out),
        .jex(qex), .jey(qey), .jdx(qdx), .jdy(qdy), .tol(tol_reg),
        .out_valid(out_valid), .out_stall(out_stall), .winding(winding),
        .status(status), .saturated(saturated)
    );

endmodule
`default_nettype wire

// ----- bench/polygon_winding_number_top_test.sv -----
`timescale 1ns / 1ps
module polygon_winding_number_top_test;
    import pwn_pkg::*;

    localparam int LIMIT = 20000;
    localparam logic [2:0] ADDR_TOL = 3'd0;

    typedef struct packed {
        logic signed [15:0] winding;
        logic [1:0]         status;
        logic               saturated;
    } wind_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] point_x = '0, point_y = '0, vertex_x = '0, vertex_y = '0;
    logic first_vertex = 1'b0, last_vertex = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] winding;
    logic [1:0] status;
    logic saturated;

    polygon_winding_number_top i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .point_x(point_x), .point_y(point_y),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .first_vertex(first_vertex),
        .last_vertex(last_vertex), .out_valid(out_valid), .out_stall(out_stall),
        .winding(winding), .status(status), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block's state.
    logic signed [63:0] qx, qy, sx, sy, px, py, halfs;
    logic on_edge, open_poly, clamped;
    logic [30:0] tol;
    wind_res_t winding_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int gap_max = 3;
    bit hold_off = 1'b0;
    int words_sent = 0;

    function automatic logic signed [127:0] mul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic bit seg_left(logic signed [63:0] x1, logic signed [63:0] y1,
                                    logic signed [63:0] x2, logic signed [63:0] y2);
        logic signed [63:0] dy;
        logic signed [127:0] l, r;
        if ((y1 > qy && y2 > qy) || (y1 < qy && y2 < qy)) return 0;
        if (x1 > qx && x2 > qx) return 1;
        if (x1 == qx && x2 == qx) return 0;
        dy = y2 - y1;
        if (dy == 0) return 0;
        l = mul(qx - x1, dy);
        r = mul(x2 - x1, qy - y1);
        return dy > 0 ? (l < r) : (r < l);
    endfunction

    function automatic bit seg_touch(logic signed [63:0] x1, logic signed [63:0] y1,
                                     logic signed [63:0] x2, logic signed [63:0] y2);
        logic signed [63:0] dx, lo, hi;
        logic signed [127:0] d, lim;
        dx = x2 - x1;
        if (qx == x1 && qy == y1) return 1;
        if (dx == 0)
        begin
            lo = y1 < y2 ? y1 : y2;
            hi = y1 < y2 ? y2 : y1;
            return qx == x1 && qy >= lo && qy <= hi;
        end
        lo = x1 < x2 ? x1 : x2;
        hi = x1 < x2 ? x2 : x1;
        if (qx < lo || qx > hi) return 0;
        d = mul(qy - y1, dx) - mul(y2 - y1, qx - x1);
        if (d < 0) d = -d;
        lim = mul({33'd0, tol}, dx < 0 ? -dx : dx);
        return !(lim < d);
    endfunction

    function automatic void add_halves(int delta);
        logic signed [63:0] v;
        v = halfs + delta;
        if (v > 131071) begin v = 131071; clamped = 1; end
        if (v < -131072) begin v = -131072; clamped = 1; end
        halfs = v;
    endfunction

    function automatic void predict_winding(logic signed [31:0] pxi, logic signed [31:0] pyi,
                                            logic signed [31:0] vxi, logic signed [31:0] vyi,
                                            logic fv, logic lv);
        logic signed [63:0] vx, vy, w;
        wind_res_t r;
        vx = vxi;
        vy = vyi;
        if (fv)
        begin
            qx = pxi; qy = pyi; sx = vx; sy = vy;
            halfs = 0; on_edge = 0; clamped = 0; open_poly = 1;
        end
        else if (open_poly)
        begin
            if (seg_touch(px, py, vx, vy)) on_edge = 1;
            if (seg_left(px, py, vx, vy))
            begin
                if (py < qy && vy > qy) add_halves(2);
                else if (py > qy && vy < qy) add_halves(-2);
                else if (py == qy && vy < qy) add_halves(-1);
                else if (py == qy && vy > qy) add_halves(1);
                else if (py < qy && vy == qy) add_halves(1);
                else if (py > qy && vy == qy) add_halves(-1);
            end
        end
        else
            return;
        px = vx; py = vy;
        if (!lv) return;
        open_poly = 0;
        if (vx != sx || vy != sy)
            r = '{winding: 16'sd0, status: ST_OPEN, saturated: 1'b0};
        else if (on_edge)
            r = '{winding: 16'sd1, status: ST_BOUND, saturated: 1'b0};
        else
        begin
            w = halfs / 2;
            r.saturated = clamped;
            if (w > 32767) begin w = 32767; r.saturated = 1; end
            if (w < -32768) begin w = -32768; r.saturated = 1; end
            r.winding = w[15:0];
            r.status = ST_OK;
        end
        winding_q.push_back(r);
    endfunction

    task automatic send_word(logic signed [31:0] pxi, logic signed [31:0] pyi,
                             logic signed [31:0] vxi, logic signed [31:0] vyi,
                             logic fv, logic lv);
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, gap_max);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= pxi; point_y <= pyi; vertex_x <= vxi; vertex_y <= vyi;
        first_vertex <= fv; last_vertex <= lv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_winding(pxi, pyi, vxi, vyi, fv, lv);
        words_sent++;
    endtask

    task automatic write_tolerance(logic [30:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (winding_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        psel <= 1; pwrite <= 1; paddr <= ADDR_TOL; pwdata <= {1'b0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        tol = v;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom;
            default: return $signed($urandom_range(0, 16)) - 8 <<< 16;
        endcase
    endfunction

    task automatic send_polygon(int n, bit close_it, logic signed [31:0] qxi,
                                logic signed [31:0] qyi);
        logic signed [31:0] fx, fy;
        fx = rand_coord();
        fy = rand_coord();
        send_word(qxi, qyi, fx, fy, 1, n == 1);
        for (int i = 1; i < n; i++)
        begin
            if (i == n - 1 && close_it)
                send_word(rand_coord(), rand_coord(), fx, fy, $urandom_range(0, 9) == 0, 1);
            else
                send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 19) == 0, i == n - 1);
        end
    endtask

    task automatic test_directed();
        // A square around the origin, traversed twice, gives winding two.
        send_word(0, 0, 32'sh10000, 32'sh10000, 1, 0);
        send_word(0, 0, -32'sh10000, 32'sh10000, 0, 0);
        send_word(0, 0, -32'sh10000, -32'sh10000, 0, 0);
        send_word(0, 0, 32'sh10000, -32'sh10000, 0, 0);
        send_word(0, 0, 32'sh10000, 32'sh10000, 0, 0);
        send_word(0, 0, -32'sh10000, 32'sh10000, 0, 0);
        send_word(0, 0, -32'sh10000, -32'sh10000, 0, 0);
        send_word(0, 0, 32'sh10000, -32'sh10000, 0, 0);
        send_word(0, 0, 32'sh10000, 32'sh10000, 0, 1);
        // Point on a vertex, an open polygon, and a single vertex.
        send_word(32'sh10000, 0, 32'sh10000, 0, 1, 0);
        send_word(0, 0, 0, 32'sh10000, 0, 0);
        send_word(0, 0, 32'sh10000, 0, 0, 1);
        send_word(0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0);
        send_word(0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 1);
        send_word(32'sh7fff_ffff, 32'sh8000_0000, 5, 5, 1, 1);
        // A word with no polygon open is dropped.
        send_word(0, 0, 3, 3, 0, 1);
        // A horizontal segment through the point and a vertical edge.
        send_word(0, 0, -32'sh10000, 0, 1, 0);
        send_word(0, 0, 32'sh10000, 0, 0, 0);
        send_word(0, 0, 0, 32'sh10000, 0, 0);
        send_word(0, 0, -32'sh10000, 0, 0, 1);
        send_word(0, 5, 0, 0, 1, 0);
        send_word(0, 0, 0, 10, 0, 0);
        send_word(0, 0, 0, 0, 0, 1);
    endtask

    task automatic test_many_turns();
        // Repeated turns around the origin, each touching the ray at two endpoints.
        send_word(0, 0, 32'sh10000, 0, 1, 0);
        for (int i = 0; i < 40; i++)
        begin
            send_word(0, 0, -32'sh10000, 32'sh10000, 0, 0);
            send_word(0, 0, -32'sh10000, -32'sh10000, 0, 0);
            send_word(0, 0, 32'sh10000, 0, 0, i == 39);
            if (i == 20) gap_max = 1;
        end
        gap_max = 3;
    endtask

    task automatic test_random(int words);
        int n;
        while (words_sent < words)
        begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            if ($urandom_range(0, 7) == 0)
                send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0,
                          $urandom_range(0, 1));
            else
                send_polygon(n, $urandom_range(0, 4) != 0, rand_coord(), rand_coord());
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                send_polygon(6, 1, 0, 0);
                send_polygon(3, 1, 0, 0);
            end
        join
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 15) < 4) && (results_seen % 7 != 3);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (winding_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: winding %0d status %0d", winding, status);
            end
            else if (winding_q[0] !== {winding, status, saturated})
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected winding %0d status %0d sat %0b, got %0d %0d %0b",
                             winding_q[0].winding, winding_q[0].status, winding_q[0].saturated,
                             winding, status, saturated);
                void'(winding_q.pop_front());
            end
            else
                void'(winding_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        tol = '0;
        open_poly = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        write_tolerance(31'h7fff_ffff);
        test_random(250);
        write_tolerance(31'd1 << 16);
        test_random(450);
        write_tolerance(31'd0);
        test_random(620);
        test_many_turns();
        in_valid <= 1'b0;
        @(posedge clk);
        while (winding_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d vertex words over three tolerances, checked %0d results.",
                 words_sent, results_seen);
        if (mismatches == 0 && winding_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
